>>> design/wfc_pkg.sv
// ----------------------------------------------------------------------------
// wfc_pkg
// Shared constants, command/status types and helpers for the word counter.
// ----------------------------------------------------------------------------
package wfc_pkg;

    localparam int DEF_TABLE_DEPTH  = 64;
    localparam int DEF_MAX_WORD_LEN = 32;

    localparam logic [5:0] MIN_LEN_RST  = 6'd4;
    localparam logic       KIND_WORD    = 1'b0;
    localparam logic       KIND_TOTALS  = 1'b1;
    localparam logic       REG_MIN_LEN  = 1'b0;

    localparam logic [7:0] CH_UP_A = 8'h41;
    localparam logic [7:0] CH_UP_Z = 8'h5A;
    localparam logic [7:0] CH_LO_A = 8'h61;
    localparam logic [7:0] CH_LO_Z = 8'h7A;
    localparam logic [7:0] CH_D0   = 8'h30;
    localparam logic [7:0] CH_D9   = 8'h39;
    localparam logic [7:0] CASE_OFS = 8'd32;

    typedef struct packed {
        logic accept;
        logic ent_clr;
        logic ent_inc;
        logic pos_clr;
        logic pos_inc;
        logic cnt_wr;
        logic ins;
        logic set_full;
        logic cp_wr;
        logic emit_word;
        logic word_last;
        logic emit_tot;
    } t_cmd;

    typedef struct packed {
        logic in_word;
        logic len_nz;
        logic ent_end;
        logic len_eq;
        logic pos_end;
        logic ch_eq;
        logic tbl_full;
        logic out_free;
    } t_sts;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

endpackage

>>> design/word_frequency_counter.sv
// ----------------------------------------------------------------------------
// word_frequency_counter
// Byte-stream word splitter with a word frequency table and text totals.
// ----------------------------------------------------------------------------
// Bytes are accepted only in the idle state. A word end searches the table
// entry by entry: a length read and compare per entry, plus a read and compare
// per byte on a length match, then a count read and write to update, or a
// byte-by-byte copy to insert (none when full), then the result is emitted.
// The entry-by-entry search loop over the table memories sets the rate.
// Synchronous active-low reset clears counters, the table fill count and the
// output register; table memories are not cleared.
module word_frequency_counter
    import wfc_pkg::*;
#(
    parameter int TABLE_DEPTH  = DEF_TABLE_DEPTH,
    parameter int MAX_WORD_LEN = DEF_MAX_WORD_LEN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [5:0] entry_index, [21:6] entry_count, [22] new_entry, [23] word_valid,
    // [24] table_full, [25] word_truncated, [41:26] char_total_out,
    // [57:42] valid_words_out
    output logic [63:0] m_axis_tdata,
    output logic        m_axis_tuser,   // kind
    output logic        m_axis_tlast,   // last
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [5:0] r_min_len;
    t_cmd       w_cmd;
    t_sts       w_sts;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_len <= MIN_LEN_RST;
        end else if (psel && penable && pwrite && paddr[2] == REG_MIN_LEN) begin
            r_min_len <= pwdata[5:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MIN_LEN) ? {26'd0, r_min_len} : 32'd0;

    wfc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_in_last  (s_axis_tlast),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    wfc_dp #(
        .TABLE_DEPTH  (TABLE_DEPTH),
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_char      (s_axis_tdata),
        .i_min_len   (r_min_len),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_kind  (m_axis_tuser),
        .o_out_last  (m_axis_tlast)
    );

    a_nonlast_is_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tuser == KIND_WORD))
        else $error("non-final result is not a word report");

    a_totals_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser == KIND_TOTALS) |-> m_axis_tlast)
        else $error("totals result not marked last");

    a_eot_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tlast) |=> !s_axis_tready)
        else $error("byte taken before totals emitted");

endmodule

>>> design/wfc_ram.sv
// ----------------------------------------------------------------------------
// wfc_ram
// Generic RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module wfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/wfc_ctrl.sv
// ----------------------------------------------------------------------------
// wfc_ctrl
// Sequencer: byte intake, table search, insert/update and result emission.
// ----------------------------------------------------------------------------
module wfc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_in_last,
    output logic          o_in_ready,
    input  wfc_pkg::t_sts i_sts,
    output wfc_pkg::t_cmd o_cmd
);
    import wfc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_LEN_RD, S_LEN_CMP, S_CH_RD, S_CH_CMP, S_CNT_RD, S_CNT_WR,
        S_MISS, S_CP_RD, S_CP_WR, S_EMIT_W, S_EMIT_T
    } t_state;

    t_state r_state, n_state;
    logic   r_eot, n_eot;
    t_cmd   w_cmd;

    always_comb begin
        n_state = r_state;
        n_eot   = r_eot;
        w_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.accept = 1'b1;
                    n_eot        = i_in_last;
                    if ((!i_sts.in_word && i_sts.len_nz) ||
                        (i_sts.in_word && i_in_last)) begin
                        w_cmd.ent_clr = 1'b1;
                        n_state       = S_LEN_RD;
                    end else if (i_in_last) begin
                        n_state = S_EMIT_T;
                    end
                end
            end
            S_LEN_RD: begin
                n_state = i_sts.ent_end ? S_MISS : S_LEN_CMP;
            end
            S_LEN_CMP: begin
                if (i_sts.len_eq) begin
                    w_cmd.pos_clr = 1'b1;
                    n_state       = S_CH_RD;
                end else begin
                    w_cmd.ent_inc = 1'b1;
                    n_state       = S_LEN_RD;
                end
            end
            S_CH_RD: begin
                n_state = i_sts.pos_end ? S_CNT_RD : S_CH_CMP;
            end
            S_CH_CMP: begin
                if (i_sts.ch_eq) begin
                    w_cmd.pos_inc = 1'b1;
                    n_state       = S_CH_RD;
                end else begin
                    w_cmd.ent_inc = 1'b1;
                    n_state       = S_LEN_RD;
                end
            end
            S_CNT_RD: begin
                n_state = S_CNT_WR;
            end
            S_CNT_WR: begin
                w_cmd.cnt_wr = 1'b1;
                n_state      = S_EMIT_W;
            end
            S_MISS: begin
                if (i_sts.tbl_full) begin
                    w_cmd.set_full = 1'b1;
                    n_state        = S_EMIT_W;
                end else begin
                    w_cmd.pos_clr = 1'b1;
                    n_state       = S_CP_RD;
                end
            end
            S_CP_RD: begin
                if (i_sts.pos_end) begin
                    w_cmd.ins = 1'b1;
                    n_state   = S_EMIT_W;
                end else begin
                    n_state = S_CP_WR;
                end
            end
            S_CP_WR: begin
                w_cmd.cp_wr   = 1'b1;
                w_cmd.pos_inc = 1'b1;
                n_state       = S_CP_RD;
            end
            S_EMIT_W: begin
                if (i_sts.out_free) begin
                    w_cmd.emit_word = 1'b1;
                    w_cmd.word_last = !r_eot;
                    n_state         = r_eot ? S_EMIT_T : S_IDLE;
                end
            end
            S_EMIT_T: begin
                if (i_sts.out_free) begin
                    w_cmd.emit_tot = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_eot   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_eot   <= n_eot;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = w_cmd;

endmodule

>>> design/wfc_dp.sv
// ----------------------------------------------------------------------------
// wfc_dp
// Datapath: word buffer, word table memories, counters and result register.
// ----------------------------------------------------------------------------
module wfc_dp #(
    parameter int TABLE_DEPTH  = wfc_pkg::DEF_TABLE_DEPTH,
    parameter int MAX_WORD_LEN = wfc_pkg::DEF_MAX_WORD_LEN
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [7:0]    i_char,
    input  logic [5:0]    i_min_len,
    input  wfc_pkg::t_cmd i_cmd,
    output wfc_pkg::t_sts o_sts,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output logic [63:0]   o_out_data,
    output logic          o_out_kind,
    output logic          o_out_last
);
    import wfc_pkg::*;

    localparam int ENT_W = $clog2(TABLE_DEPTH);
    localparam int EC_W  = $clog2(TABLE_DEPTH + 1);
    localparam int LEN_W = $clog2(MAX_WORD_LEN + 1);
    localparam int PW    = $clog2(MAX_WORD_LEN);
    localparam int CD    = TABLE_DEPTH * MAX_WORD_LEN;
    localparam int CA_W  = $clog2(CD);

    logic [LEN_W-1:0] r_len;
    logic             r_trunc;
    logic [7:0]       r_first;
    logic [EC_W-1:0]  r_ent;
    logic [LEN_W-1:0] r_pos;
    logic [EC_W-1:0]  r_used;
    logic [15:0]      r_char_tot;
    logic [15:0]      r_word_tot;
    logic [15:0]      r_inv_tot;
    logic [5:0]       r_res_idx;
    logic [15:0]      r_res_cnt;
    logic             r_res_new;
    logic             r_res_full;
    logic             r_out_valid;
    logic [63:0]      r_out_data;
    logic             r_out_kind;
    logic             r_out_last;

    logic [7:0]       w_fold;
    logic             w_word;
    logic             w_room;
    logic             w_valid;
    logic [CA_W-1:0]  w_caddr;
    logic [7:0]       w_wbuf_rd;
    logic [7:0]       w_chars_rd;
    logic [LEN_W-1:0] w_lens_rd;
    logic [15:0]      w_cnt_rd;
    logic [15:0]      w_valid_words;

    always_comb begin
        w_fold = i_char;
        if (i_char >= CH_UP_A && i_char <= CH_UP_Z) begin
            w_fold = i_char + CASE_OFS;
        end
    end

    assign w_word  = (w_fold >= CH_LO_A && w_fold <= CH_LO_Z) ||
                     (w_fold >= CH_D0 && w_fold <= CH_D9);
    assign w_room  = (r_len < LEN_W'(MAX_WORD_LEN));
    assign w_valid = !(r_first >= CH_D0 && r_first <= CH_D9) &&
                     (7'(r_len) >= 7'(i_min_len));
    assign w_caddr = CA_W'(r_ent[ENT_W-1:0]) * CA_W'(MAX_WORD_LEN) + CA_W'(r_pos);
    assign w_valid_words = r_word_tot - r_inv_tot;

    wfc_ram #(.WIDTH(8), .DEPTH(MAX_WORD_LEN)) u_wbuf (
        .i_clk   (i_clk),
        .i_we    (i_cmd.accept && w_word && w_room),
        .i_waddr (r_len[PW-1:0]),
        .i_wdata (w_fold),
        .i_raddr (r_pos[PW-1:0]),
        .o_rdata (w_wbuf_rd)
    );

    wfc_ram #(.WIDTH(8), .DEPTH(CD)) u_chars (
        .i_clk   (i_clk),
        .i_we    (i_cmd.cp_wr),
        .i_waddr (w_caddr),
        .i_wdata (w_wbuf_rd),
        .i_raddr (w_caddr),
        .o_rdata (w_chars_rd)
    );

    wfc_ram #(.WIDTH(LEN_W), .DEPTH(TABLE_DEPTH)) u_lens (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ins),
        .i_waddr (r_ent[ENT_W-1:0]),
        .i_wdata (r_len),
        .i_raddr (r_ent[ENT_W-1:0]),
        .o_rdata (w_lens_rd)
    );

    wfc_ram #(.WIDTH(16), .DEPTH(TABLE_DEPTH)) u_counts (
        .i_clk   (i_clk),
        .i_we    (i_cmd.ins || i_cmd.cnt_wr),
        .i_waddr (r_ent[ENT_W-1:0]),
        .i_wdata (i_cmd.ins ? 16'd1 : sat_inc(w_cnt_rd)),
        .i_raddr (r_ent[ENT_W-1:0]),
        .o_rdata (w_cnt_rd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= '0;
            r_trunc     <= 1'b0;
            r_used      <= '0;
            r_char_tot  <= '0;
            r_word_tot  <= '0;
            r_inv_tot   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_char_tot <= sat_inc(r_char_tot);
                if (w_word && w_room) begin
                    r_len <= r_len + LEN_W'(1);
                end else if (w_word) begin
                    r_trunc <= 1'b1;
                end
            end
            if (i_cmd.ins) begin
                r_used <= r_used + EC_W'(1);
            end
            if (i_cmd.emit_word) begin
                r_len      <= '0;
                r_trunc    <= 1'b0;
                r_word_tot <= sat_inc(r_word_tot);
                if (!w_valid) begin
                    r_inv_tot <= sat_inc(r_inv_tot);
                end
            end
            if (i_cmd.emit_tot) begin
                r_len      <= '0;
                r_trunc    <= 1'b0;
                r_used     <= '0;
                r_char_tot <= '0;
                r_word_tot <= '0;
                r_inv_tot  <= '0;
            end
            if (i_cmd.emit_word || i_cmd.emit_tot) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && w_word && r_len == '0) begin
            r_first <= w_fold;
        end
        if (i_cmd.ent_clr) begin
            r_ent <= '0;
        end else if (i_cmd.ent_inc) begin
            r_ent <= r_ent + EC_W'(1);
        end
        if (i_cmd.pos_clr) begin
            r_pos <= '0;
        end else if (i_cmd.pos_inc) begin
            r_pos <= r_pos + LEN_W'(1);
        end
        if (i_cmd.ent_clr) begin
            r_res_idx  <= '0;
            r_res_cnt  <= '0;
            r_res_new  <= 1'b0;
            r_res_full <= 1'b0;
        end else if (i_cmd.cnt_wr) begin
            r_res_idx <= 6'(r_ent);
            r_res_cnt <= sat_inc(w_cnt_rd);
        end else if (i_cmd.ins) begin
            r_res_idx <= 6'(r_ent);
            r_res_cnt <= 16'd1;
            r_res_new <= 1'b1;
        end else if (i_cmd.set_full) begin
            r_res_full <= 1'b1;
        end
        if (i_cmd.emit_word) begin
            r_out_kind <= KIND_WORD;
            r_out_last <= i_cmd.word_last;
            r_out_data <= {6'd0, 16'd0, 16'd0, r_trunc, r_res_full, w_valid,
                           r_res_new, r_res_cnt, r_res_idx};
        end else if (i_cmd.emit_tot) begin
            r_out_kind <= KIND_TOTALS;
            r_out_last <= 1'b1;
            r_out_data <= {6'd0, w_valid_words, r_char_tot, 4'd0, 16'd0, 6'd0};
        end
    end

    assign o_sts.in_word  = w_word;
    assign o_sts.len_nz   = (r_len != '0);
    assign o_sts.ent_end  = (r_ent == r_used);
    assign o_sts.len_eq   = (w_lens_rd == r_len);
    assign o_sts.pos_end  = (r_pos == r_len);
    assign o_sts.ch_eq    = (w_chars_rd == w_wbuf_rd);
    assign o_sts.tbl_full = (r_used == EC_W'(TABLE_DEPTH));
    assign o_sts.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_kind  = r_out_kind;
    assign o_out_last  = r_out_last;

endmodule

>>> bench/word_frequency_counter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_frequency_counter_tb
// Streams text bytes into the word counter and compares every word report and
// text total against an in-bench word table, across several minimum lengths.
// ----------------------------------------------------------------------------
module word_frequency_counter_tb;
    import wfc_pkg::*;

    localparam int TBL_DEPTH = DEF_TABLE_DEPTH;
    localparam int WORD_MAX  = DEF_MAX_WORD_LEN;
    localparam int CYC_LIMIT = 4000000;
    localparam int HOLD_LEN  = 400;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
    } t_byte;

    typedef struct packed {
        logic        kind;
        logic [5:0]  idx;
        logic [15:0] cnt;
        logic        fresh;
        logic        valid;
        logic        full;
        logic        trunc;
        logic [15:0] chars;
        logic [15:0] vwords;
        logic        last;
    } t_report;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    word_frequency_counter u_top (.*);

    // predictor state
    logic [5:0]  min_len;
    logic [7:0]  cur_word [WORD_MAX];
    int          cur_len = 0;
    logic        cur_trunc = 1'b0;
    logic [7:0]  tbl_chars [TBL_DEPTH][WORD_MAX];
    int          tbl_lens [TBL_DEPTH];
    logic [15:0] tbl_counts [TBL_DEPTH];
    int          used = 0;
    logic [15:0] char_cnt = '0;
    logic [15:0] word_cnt = '0;
    logic [15:0] bad_cnt = '0;

    t_byte   text_q [$];
    t_report report_q [$];
    int      n_fail = 0;
    int      cycles = 0;
    int      send_wait, recv_wait;
    int      hold_cnt;
    bit      hold_go = 1'b0;
    bit      hold_done;

    function automatic logic [15:0] sat16(logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic void clear_text();
        cur_len = 0; cur_trunc = 1'b0; used = 0;
        char_cnt = '0; word_cnt = '0; bad_cnt = '0;
    endfunction

    function automatic t_report close_word();
        t_report r;
        int      hit;
        bit      same;
        r = '0;
        r.valid = !(cur_word[0] >= CH_D0 && cur_word[0] <= CH_D9) && cur_len >= min_len;
        word_cnt = sat16(word_cnt);
        if (!r.valid) bad_cnt = sat16(bad_cnt);
        hit = -1;
        for (int e = 0; e < used && hit < 0; e++) begin
            same = (tbl_lens[e] == cur_len);
            for (int k = 0; k < cur_len && same; k++)
                if (tbl_chars[e][k] != cur_word[k]) same = 1'b0;
            if (same) hit = e;
        end
        if (hit >= 0) begin
            tbl_counts[hit] = sat16(tbl_counts[hit]);
            r.idx = hit[5:0];
            r.cnt = tbl_counts[hit];
        end else if (used < TBL_DEPTH) begin
            for (int k = 0; k < cur_len; k++) tbl_chars[used][k] = cur_word[k];
            tbl_lens[used] = cur_len;
            tbl_counts[used] = 16'd1;
            r.idx = used[5:0];
            r.cnt = 16'd1;
            r.fresh = 1'b1;
            used++;
        end else begin
            r.full = 1'b1;
        end
        r.trunc = cur_trunc;
        cur_len = 0;
        cur_trunc = 1'b0;
        return r;
    endfunction

    function automatic void predict_byte(t_byte b);
        t_report outs [$];
        t_report t;
        logic [7:0] c;
        c = b.ch;
        char_cnt = sat16(char_cnt);
        if (c >= CH_UP_A && c <= CH_UP_Z) c = c + CASE_OFS;
        if ((c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_D0 && c <= CH_D9)) begin
            if (cur_len < WORD_MAX) begin
                cur_word[cur_len] = c;
                cur_len++;
            end else cur_trunc = 1'b1;
        end else if (cur_len > 0) begin
            outs.push_back(close_word());
        end
        if (b.eot) begin
            if (cur_len > 0) outs.push_back(close_word());
            t = '0;
            t.kind = KIND_TOTALS;
            t.chars = char_cnt;
            t.vwords = word_cnt - bad_cnt;
            outs.push_back(t);
            clear_text();
        end
        if (outs.size() > 0) outs[outs.size()-1].last = 1'b1;
        foreach (outs[i]) report_q.push_back(outs[i]);
    endfunction

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYC_LIMIT) begin
            $display("** word_frequency_counter: FAILED **");
            $finish;
        end
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata <= 8'd0;
            s_axis_tlast <= 1'b0;
            send_wait <= 0;
        end else if (s_axis_tvalid && !s_axis_tready) begin
        end else if (send_wait > 0) begin
            if (s_axis_tvalid) predict_byte({s_axis_tdata, s_axis_tlast});
            s_axis_tvalid <= 1'b0;
            send_wait <= send_wait - 1;
        end else begin
            if (s_axis_tvalid) predict_byte({s_axis_tdata, s_axis_tlast});
            if (text_q.size() > 0) begin
                t_byte b;
                b = text_q.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= b.ch;
                s_axis_tlast <= b.eot;
                send_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 0;
            end else s_axis_tvalid <= 1'b0;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_report got, exp;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            recv_wait <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tuser, m_axis_tdata[5:0], m_axis_tdata[21:6],
                       m_axis_tdata[22], m_axis_tdata[23], m_axis_tdata[24],
                       m_axis_tdata[25], m_axis_tdata[41:26], m_axis_tdata[57:42],
                       m_axis_tlast};
                if (report_q.size() == 0) begin
                    $display("%0t: unexpected word, expected none actual %h", $time, got);
                    n_fail++;
                end else begin
                    exp = report_q.pop_front();
                    if (got !== exp) begin
                        $display("%0t: mismatch, expected %h actual %h", $time, exp, got);
                        n_fail++;
                    end
                end
                recv_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 9) : 0;
                m_axis_tready <= 1'b0;
            end else if (hold_go && !hold_done) begin
                m_axis_tready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait <= recv_wait - 1;
                m_axis_tready <= 1'b0;
            end else m_axis_tready <= 1'b1;
        end
    end

    // long receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_cnt <= 0;
            hold_done <= 1'b0;
        end else if (hold_go && !hold_done) begin
            if (hold_cnt == HOLD_LEN - 1) hold_done <= 1'b1;
            hold_cnt <= hold_cnt + 1;
        end
    end

    task automatic apb_write(logic [5:0] v);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'd0; pwdata <= {26'd0, v};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        min_len = v;
    endtask

    task automatic drain();
        while (text_q.size() > 0 || s_axis_tvalid || report_q.size() > 0)
            @(posedge i_clk);
        repeat (TBL_DEPTH * (2 + 2 * WORD_MAX) + 200) @(posedge i_clk);
    endtask

    task automatic push_word(string s, logic [7:0] sep, bit eot);
        for (int i = 0; i < s.len(); i++) text_q.push_back({s[i], 1'b0});
        text_q.push_back({sep, eot});
    endtask

    task automatic push_rand_text(int nbytes);
        int     n, len;
        logic [7:0] c;
        n = 0;
        while (n < nbytes) begin
            len = $urandom_range(1, 8);
            if ($urandom_range(0, 30) == 0) len = $urandom_range(30, 40);
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(0, 5))
                    0: c = CH_D0 + 8'($urandom_range(0, 2));
                    1: c = CH_UP_A + 8'($urandom_range(0, 3));
                    default: c = CH_LO_A + 8'($urandom_range(0, 3));
                endcase
                if ($urandom_range(0, 40) == 0) c = 8'($urandom_range(0, 255));
                text_q.push_back({c, 1'b0});
            end
            c = ($urandom_range(0, 1)) ? 8'h20 : 8'($urandom_range(0, 255));
            text_q.push_back({c, 1'b0});
            n += len + 1;
        end
        text_q.push_back({8'($urandom_range(0, 255)), 1'b1});
    endtask

    initial begin
        logic [5:0] mins [4] = '{6'd1, 6'd32, 6'd0, 6'd63};
        i_rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        min_len = MIN_LEN_RST;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // directed: case, digits, empty words, long word, end with open word
        push_word("Hello", 8'h20, 0);
        push_word("hello", 8'h2E, 0);
        text_q.push_back({8'h2C, 1'b0});
        push_word("9lives", 8'h21, 0);
        push_word("abc", 8'hFF, 0);
        push_word("ZZZZzzzzaaaaaaaaaaaaaaaaaaaaaaaaaaaaaa", 8'h3F, 0);
        push_word("end", 8'h00, 0);
        text_q.push_back({8'h7A, 1'b1});
        text_q.push_back({8'h20, 1'b1});
        drain();
        // fill table beyond 64 entries, with long hold-off
        for (int i = 0; i < 70; i++)
            push_word($sformatf("w%0d", i), 8'h20, 0);
        text_q.push_back({8'h80, 1'b1});
        hold_go = 1'b1;
        drain();
        foreach (mins[m]) begin
            apb_write(mins[m]);
            for (int t = 0; t < 4; t++) push_rand_text($urandom_range(20, 60));
            drain();
        end
        if (n_fail == 0)
            $display("** word_frequency_counter: PASSED **");
        else
            $display("** word_frequency_counter: FAILED **");
        $finish;
    end

endmodule
